// File: src/p2a_pkg.sv
// Package: shared types, constants and codes of the power-of-two class block allocator.
package p2a_pkg;

	localparam int NUM_CLASSES = 8;
	localparam int NUM_HANDLES = 256;
	localparam int CLS_W = 3;
	localparam int HND_W = 8;
	localparam int CNT_W = 9;
	localparam int CLSN_W = 4;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_ADD   = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_LEN = 3'd1;
	localparam logic [2:0] ST_NO_FREE = 3'd2;
	localparam logic [2:0] ST_BAD_FRE = 3'd3;
	localparam logic [2:0] ST_BAD_ADD = 3'd4;

	localparam logic [1:0] HS_UNKNOWN = 2'd0;
	localparam logic [1:0] HS_FREE    = 2'd1;
	localparam logic [1:0] HS_USED    = 2'd2;

	localparam logic CFG_MIN_LOG2 = 1'b0;
	localparam logic CFG_CLASSES  = 1'b1;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic [1:0]       action;
		logic             len_bad;
		logic [CLS_W-1:0] cls;
		logic [HND_W-1:0] handle;
		logic             class_bad;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [HND_W-1:0] granted_handle;
		logic [CLS_W-1:0] served_class;
		logic [CNT_W-1:0] free_left;
		logic [CNT_W-1:0] used_peak;
	} rsp_t;

endpackage

// File: src/p2a_front.sv
// Front part: rounds the length to a class and checks class ranges.
module p2a_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [4:0]        cfg_data,
	input  logic              in_valid,
	input  logic [1:0]        action,
	input  logic [31:0]       request_length,
	input  logic [7:0]        block_handle,
	input  logic [2:0]        target_class,
	output logic [3:0]        eff_n,
	output logic              cmd_valid,
	output p2a_pkg::cmd_t     cmd
);
	import p2a_pkg::*;

	logic [4:0] min_log2_q;
	logic [3:0] class_count_q;
	logic [5:0] lg;
	logic [5:0] cls_full;
	logic [31:0] lm1;
	cmd_t cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_log2_q    <= 5'd4;
			class_count_q <= 4'd8;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_MIN_LOG2) min_log2_q <= cfg_data;
			else class_count_q <= cfg_data[3:0];
		end
	end

	always_comb begin
		if (class_count_q == 4'd0) eff_n = 4'd1;
		else if (class_count_q > 4'(NUM_CLASSES)) eff_n = 4'(NUM_CLASSES);
		else eff_n = class_count_q;
	end

	// ceil(log2(len)) = bit length of len-1
	always_comb begin
		lm1 = request_length - 32'd1;
		lg = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (lm1[i]) lg = 6'(i + 1);
		end
		cls_full = (lg <= {1'b0, min_log2_q}) ? 6'd0 : lg - {1'b0, min_log2_q};
		cmd_d.action    = action;
		cmd_d.handle    = block_handle;
		cmd_d.len_bad   = (request_length == 32'd0) || (cls_full >= {2'b00, eff_n});
		cmd_d.cls       = (action == ACT_ADD) ? target_class : cls_full[2:0];
		cmd_d.class_bad = ({1'b0, target_class} >= eff_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_valid <= 1'b0;
		else cmd_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid) cmd <= cmd_d;
	end
endmodule

// File: src/p2a_back.sv
// Back part: per-class free FIFOs, handle tables and result formation.
module p2a_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  p2a_pkg::cmd_t     cmd,
	input  logic [3:0]        eff_n,
	output logic              busy,
	output logic              rsp_valid,
	output p2a_pkg::rsp_t     rsp
);
	import p2a_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [HND_W-1:0] next_link [NUM_HANDLES];
	logic [CLS_W-1:0] handle_class [NUM_HANDLES];
	logic [1:0] hstat_q [NUM_HANDLES];
	logic [HND_W-1:0] head_q [NUM_CLASSES];
	logic [HND_W-1:0] tail_q [NUM_CLASSES];
	logic [CNT_W-1:0] free_q [NUM_CLASSES];
	logic [CNT_W-1:0] owned_q [NUM_CLASSES];
	logic [CNT_W-1:0] peak_q [NUM_CLASSES];
	logic [CLS_W-1:0] hcls_rd_q;
	logic [1:0] hst_rd_q;
	logic [HND_W-1:0] link_rd_q;
	logic [HND_W-1:0] pop_h_q;
	logic [CLS_W-1:0] pop_c_q;
	logic [HND_W-1:0] clr_q;
	logic found;
	logic [CLS_W-1:0] fcls;
	logic [CNT_W-1:0] used_n;
	logic [CLS_W-1:0] pc;
	logic put_ok;
	logic hs_we;
	logic [HND_W-1:0] hs_addr;
	logic [1:0] hs_wd;

	assign busy = (state_q != S_IDLE) || cmd_valid;

	// first non-empty class at or above the requested one
	always_comb begin
		found = 1'b0;
		fcls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (c >= int'(cmd_q.cls) && c < int'(eff_n) && free_q[c] != '0) begin
				found = 1'b1;
				fcls = CLS_W'(c);
			end
		end
	end

	assign pc = cmd_q.action == ACT_FREE ? hcls_rd_q : cmd_q.cls;
	assign used_n = owned_q[pop_c_q] - free_q[pop_c_q];
	assign put_ok = (cmd_q.action == ACT_FREE && hst_rd_q == HS_USED) ||
	                (cmd_q.action == ACT_ADD && hst_rd_q == HS_UNKNOWN && !cmd_q.class_bad);

	// single write port of the handle status memory
	always_comb begin
		hs_we   = 1'b0;
		hs_addr = cmd_q.handle;
		hs_wd   = HS_FREE;
		if (state_q == S_CLR) begin
			hs_we   = 1'b1;
			hs_addr = clr_q;
			hs_wd   = HS_UNKNOWN;
		end else if (state_q == S_EXEC) begin
			if (cmd_q.action == ACT_ALLOC) begin
				if (!cmd_q.len_bad && found) begin
					hs_we   = 1'b1;
					hs_addr = head_q[fcls];
					hs_wd   = HS_USED;
				end
			end else if (put_ok) begin
				hs_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hcls_rd_q <= handle_class[cmd_q.handle];
		hst_rd_q  <= hstat_q[cmd_q.handle];
		link_rd_q <= next_link[head_q[fcls]];
		if (hs_we) hstat_q[hs_addr] <= hs_wd;
		if (state_q == S_EXEC && cmd_q.action != ACT_ALLOC && free_q[pc] != '0) begin
			if ((cmd_q.action == ACT_FREE && hst_rd_q == HS_USED) ||
			    (cmd_q.action == ACT_ADD && hst_rd_q == HS_UNKNOWN && !cmd_q.class_bad))
				next_link[tail_q[pc]] <= cmd_q.handle;
		end
		if (state_q == S_EXEC && cmd_q.action == ACT_ADD && hst_rd_q == HS_UNKNOWN &&
		    !cmd_q.class_bad)
			handle_class[cmd_q.handle] <= cmd_q.cls;
		if (state_q == S_EXEC) begin
			pop_h_q <= head_q[fcls];
			pop_c_q <= fcls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			rsp_valid <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				free_q[c]  <= '0;
				owned_q[c] <= '0;
				peak_q[c]  <= '0;
			end
		end else begin
			rsp_valid <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					// sweep one handle status entry per cycle
					clr_q <= clr_q + 1'b1;
					if (clr_q == HND_W'(NUM_HANDLES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					rsp     <= '0;
					rsp_valid <= 1'b1;
					priority case (cmd_q.action)
						ACT_ALLOC: begin
							if (cmd_q.len_bad) rsp.status <= ST_BAD_LEN;
							else if (!found) begin
								rsp.status       <= ST_NO_FREE;
								rsp.served_class <= cmd_q.cls;
								rsp.free_left    <= free_q[cmd_q.cls];
								rsp.used_peak    <= peak_q[cmd_q.cls];
							end else begin
								rsp_valid <= 1'b0;
								state_q   <= S_LINK;
								free_q[fcls] <= free_q[fcls] - 1'b1;
							end
						end
						ACT_FREE, ACT_ADD: begin
							if ((cmd_q.action == ACT_FREE && hst_rd_q == HS_USED) ||
							    (cmd_q.action == ACT_ADD && hst_rd_q == HS_UNKNOWN &&
							     !cmd_q.class_bad)) begin
								if (free_q[pc] == '0) head_q[pc] <= cmd_q.handle;
								tail_q[pc] <= cmd_q.handle;
								free_q[pc] <= free_q[pc] + 1'b1;
								if (cmd_q.action == ACT_ADD) owned_q[pc] <= owned_q[pc] + 1'b1;
								rsp.served_class <= pc;
								rsp.free_left    <= free_q[pc] + 1'b1;
								rsp.used_peak    <= peak_q[pc];
							end else begin
								rsp.status <= (cmd_q.action == ACT_FREE) ? ST_BAD_FRE : ST_BAD_ADD;
							end
						end
						default: rsp.status <= ST_BAD_ADD;
					endcase
				end
				S_LINK: begin
					if (free_q[pop_c_q] != '0) head_q[pop_c_q] <= link_rd_q;
					if (used_n > peak_q[pop_c_q]) peak_q[pop_c_q] <= used_n;
					rsp.status         <= ST_OK;
					rsp.granted_handle <= pop_h_q;
					rsp.served_class   <= pop_c_q;
					rsp.free_left      <= free_q[pop_c_q];
					rsp.used_peak      <= (used_n > peak_q[pop_c_q]) ? used_n : peak_q[pop_c_q];
					rsp_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> busy) else $error("busy low with queued command");
	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid) else $error("back-to-back results");
	a_link_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |=> rsp_valid) else $error("allocate without result");
endmodule

// File: src/pow2_class_block_allocator_unit.sv
// Top level of the power-of-two class block allocator.
//
//  channel   | handshake        | payload
//  ----------+------------------+-----------------------------------------------
//  command   | start & !busy    | action, request_length, block_handle, target_class
//  result    | done (one cycle) | status, granted_handle, served_class, free_left, used_peak
//  config    | cfg_we           | cfg_idx, cfg_data
//
// An item passes through these steps: the front registers the classified
// transaction, the back loads it, reads the handle status, executes, and for a
// successful allocate fetches the next link of the popped handle from the link memory.
// Reset clears control and counter state at once, then sweeps every entry of the handle
// status memory one entry per cycle; busy stays high during the sweep.
// The receiver cannot stall: each result shows for one cycle on done.
module pow2_class_block_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] request_length,
	input  logic [7:0]  block_handle,
	input  logic [2:0]  target_class,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  granted_handle,
	output logic [2:0]  served_class,
	output logic [8:0]  free_left,
	output logic [8:0]  used_peak,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [4:0]  cfg_data
);
	import p2a_pkg::*;

	logic       cmd_valid;
	cmd_t       cmd;
	logic [3:0] eff_n;
	rsp_t       rsp;
	logic       back_busy;

	// Accept only when the back side has drained: the front register is the queue.
	assign busy = back_busy;

	p2a_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_valid(start && !busy), .action, .request_length, .block_handle,
		.target_class, .eff_n, .cmd_valid, .cmd
	);

	p2a_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .eff_n,
		.busy(back_busy), .rsp_valid(done), .rsp
	);

	// Drive result ports from the result register.
	assign status         = rsp.status;
	assign granted_handle = rsp.granted_handle;
	assign served_class   = rsp.served_class;
	assign free_left      = rsp.free_left;
	assign used_peak      = rsp.used_peak;
endmodule
